[design/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; define ASSERT_OFF to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_SEQ(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, cond)
`define ASSERT_SEQ(label, clk, rst_n, ante, cons)
`endif
`endif

[design/rms_pkg.sv]
// Package for the rate monotonic scheduler: kinds, status codes, phases, states.
// Depends on nothing.
`timescale 1ns / 1ps
package rms_pkg;
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_YIELD = 2'd1;
    localparam logic [1:0] KIND_DEREG = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_REFUSED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO_PER = 3'd4;

    localparam logic [1:0] PH_READY = 2'd0;
    localparam logic [1:0] PH_SLEEP = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_NEW   = 2'd3;

    localparam logic [13:0] UTIL_RESET = 14'd6930;
    localparam logic [13:0] UTIL_SCALE = 14'd10000;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_APPLY = 7'b0001000,
        S_DISP  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;
endpackage

[design/rate_monotonic_task_scheduler.sv]
// Rate monotonic task scheduler with utilization admission control.
// A register runs the serial 30-step divider, a one-slot-per-cycle scan, apply and output; a
// found yield and every tick add a dispatch scan and a finish step, and a deregister adds them
// only when it frees the running task; a zero period goes straight to output. The next
// transaction is taken once the result leaves. Reset (rst_n, asynchronous, active low) clears
// slot valid bits, time, running slot, sets util_limit to 6930; uses rms_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rate_monotonic_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [21:0] pid,
    input  logic [15:0] task_period,
    input  logic [15:0] comp_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        running_valid,
    output logic [21:0] running_pid,
    output logic        preempted_valid,
    output logic [21:0] preempted_pid,
    output logic [13:0] util_total
);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    // Slot table: payload registers, valid bits reset.
    logic [MAX_TASKS-1:0] valid_reg;
    logic [21:0] spid_reg [MAX_TASKS];
    logic [15:0] sper_reg [MAX_TASKS];
    logic [13:0] sterm_reg [MAX_TASKS];
    logic [1:0]  sph_reg [MAX_TASKS];
    logic [31:0] sdl_reg [MAX_TASKS];

    logic [13:0] limit_reg;
    logic [31:0] now_reg;
    logic        cur_v_reg;
    logic [IW-1:0] cur_reg;
    logic [13:0] total_reg;   // running sum of valid terms

    rms_pkg::state_t state_reg;
    logic [1:0]  kind_reg;
    logic [21:0] pid_reg;
    logic [15:0] per_reg;
    logic [29:0] num_reg;     // comp*10000, shifted out one bit per step
    logic [16:0] rem_reg;
    logic [29:0] quo_reg;
    logic [4:0]  dcnt_reg;
    logic [CW-1:0] idx_reg;
    logic        hit_reg;
    logic [IW-1:0] hidx_reg;
    logic        best_v_reg;
    logic [IW-1:0] best_reg;
    logic [2:0]  st_reg;
    logic        pre_v_reg;
    logic [21:0] pre_pid_reg;

    // APB port: always ready, single register at index zero.
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {18'd0, limit_reg} : 32'd0;
    wire cfg_wr = psel && penable && pwrite && pready;

    assign in_stall = (state_reg != rms_pkg::S_IDLE);
    assign out_valid = (state_reg == rms_pkg::S_OUT);
    assign status = st_reg;
    assign running_valid = cur_v_reg;
    assign running_pid = cur_v_reg ? spid_reg[cur_reg] : 22'd0;
    assign preempted_valid = pre_v_reg;
    assign preempted_pid = pre_v_reg ? pre_pid_reg : 22'd0;
    assign util_total = total_reg;

    wire [IW-1:0] idx = idx_reg[IW-1:0];
    wire          last = (idx_reg == CW'(MAX_TASKS - 1));
    // Restoring-division step.
    wire [16:0] rtry = {rem_reg[15:0], num_reg[29]};
    wire        rge  = rtry >= {1'b0, per_reg};
    // Exact sum check: term could exceed 14 bits before refusal.
    wire [30:0] admit_sum = {17'd0, total_reg} + {1'b0, quo_reg};
    wire [31:0] dl_add = sdl_reg[hidx_reg] + {16'd0, sper_reg[hidx_reg]};
    wire [31:0] dl_new = now_reg + {16'd0, sper_reg[hidx_reg]};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= rms_pkg::S_IDLE;
            valid_reg <= '0;
            limit_reg <= rms_pkg::UTIL_RESET;
            now_reg <= '0;
            cur_v_reg <= 1'b0;
            cur_reg <= '0;
            total_reg <= '0;
            pre_v_reg <= 1'b0;
        end else begin
            if (cfg_wr && paddr == 2'd0) begin
                limit_reg <= pwdata[13:0];
            end
            case (state_reg)
                rms_pkg::S_IDLE: begin
                    if (in_valid) begin
                        kind_reg <= kind;
                        pid_reg <= pid;
                        per_reg <= task_period;
                        num_reg <= 30'(comp_ms) * 30'(rms_pkg::UTIL_SCALE);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        dcnt_reg <= '0;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        best_v_reg <= 1'b0;
                        pre_v_reg <= 1'b0;
                        st_reg <= rms_pkg::ST_OK;
                        if (kind == rms_pkg::KIND_REG) begin
                            if (task_period == 16'd0) begin
                                st_reg <= rms_pkg::ST_ZERO_PER;
                                state_reg <= rms_pkg::S_OUT;
                            end else begin
                                state_reg <= rms_pkg::S_DIV;
                            end
                        end else if (kind == rms_pkg::KIND_TICK) begin
                            now_reg <= now_reg + 32'd1;
                            state_reg <= rms_pkg::S_SCAN;
                        end else begin
                            state_reg <= rms_pkg::S_SCAN;
                        end
                    end
                end
                rms_pkg::S_DIV: begin
                    num_reg <= {num_reg[28:0], 1'b0};
                    rem_reg <= rge ? (rtry - {1'b0, per_reg}) : rtry;
                    quo_reg <= {quo_reg[28:0], rge};
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd29) begin
                        state_reg <= rms_pkg::S_SCAN;
                    end
                end
                rms_pkg::S_SCAN: begin
                    // One slot per cycle: free slot, pid match, or tick wakeup.
                    if (kind_reg == rms_pkg::KIND_TICK) begin
                        if (valid_reg[idx] && sph_reg[idx] == rms_pkg::PH_SLEEP &&
                            sdl_reg[idx] <= now_reg) begin
                            sph_reg[idx] <= rms_pkg::PH_READY;
                        end
                    end else if (!hit_reg) begin
                        if (kind_reg == rms_pkg::KIND_REG ? !valid_reg[idx]
                            : (valid_reg[idx] && spid_reg[idx] == pid_reg)) begin
                            hit_reg <= 1'b1;
                            hidx_reg <= idx;
                        end
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (last) begin
                        state_reg <= rms_pkg::S_APPLY;
                    end
                end
                rms_pkg::S_APPLY: begin
                    idx_reg <= '0;
                    state_reg <= rms_pkg::S_OUT;
                    case (kind_reg)
                        rms_pkg::KIND_REG: begin
                            if (admit_sum > {17'd0, limit_reg}) begin
                                st_reg <= rms_pkg::ST_REFUSED;
                            end else if (!hit_reg) begin
                                st_reg <= rms_pkg::ST_FULL;
                            end else begin
                                valid_reg[hidx_reg] <= 1'b1;
                                spid_reg[hidx_reg] <= pid_reg;
                                sper_reg[hidx_reg] <= per_reg;
                                sterm_reg[hidx_reg] <= quo_reg[13:0];
                                sph_reg[hidx_reg] <= rms_pkg::PH_NEW;
                                sdl_reg[hidx_reg] <= '0;
                                total_reg <= admit_sum[13:0];
                            end
                        end
                        rms_pkg::KIND_YIELD: begin
                            if (!hit_reg) begin
                                st_reg <= rms_pkg::ST_NOT_FOUND;
                            end else begin
                                if (sph_reg[hidx_reg] == rms_pkg::PH_SLEEP ||
                                    sph_reg[hidx_reg] == rms_pkg::PH_NEW) begin
                                    sdl_reg[hidx_reg] <= dl_new;
                                    sph_reg[hidx_reg] <= rms_pkg::PH_SLEEP;
                                end else begin
                                    sdl_reg[hidx_reg] <= dl_add;
                                    sph_reg[hidx_reg] <= (dl_add > now_reg) ?
                                        rms_pkg::PH_SLEEP : rms_pkg::PH_READY;
                                end
                                if (cur_v_reg && cur_reg == hidx_reg) begin
                                    cur_v_reg <= 1'b0;
                                end
                                state_reg <= rms_pkg::S_DISP;
                            end
                        end
                        rms_pkg::KIND_DEREG: begin
                            if (!hit_reg) begin
                                st_reg <= rms_pkg::ST_NOT_FOUND;
                            end else begin
                                valid_reg[hidx_reg] <= 1'b0;
                                total_reg <= total_reg - sterm_reg[hidx_reg];
                                if (cur_v_reg && cur_reg == hidx_reg) begin
                                    cur_v_reg <= 1'b0;
                                    state_reg <= rms_pkg::S_DISP;
                                end
                            end
                        end
                        default: begin
                            state_reg <= rms_pkg::S_DISP;
                        end
                    endcase
                end
                rms_pkg::S_DISP: begin
                    // Shortest-period ready search, lowest index wins ties.
                    if (valid_reg[idx] && sph_reg[idx] == rms_pkg::PH_READY &&
                        (!best_v_reg || sper_reg[idx] < sper_reg[best_reg])) begin
                        best_v_reg <= 1'b1;
                        best_reg <= idx;
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (last) begin
                        state_reg <= rms_pkg::S_FIN;
                    end
                end
                rms_pkg::S_FIN: begin
                    state_reg <= rms_pkg::S_OUT;
                    if (best_v_reg) begin
                        if (!cur_v_reg) begin
                            sph_reg[best_reg] <= rms_pkg::PH_RUN;
                            cur_v_reg <= 1'b1;
                            cur_reg <= best_reg;
                        end else if (sper_reg[best_reg] < sper_reg[cur_reg]) begin
                            sph_reg[cur_reg] <= rms_pkg::PH_READY;
                            pre_v_reg <= 1'b1;
                            pre_pid_reg <= spid_reg[cur_reg];
                            sph_reg[best_reg] <= rms_pkg::PH_RUN;
                            cur_reg <= best_reg;
                        end
                    end
                end
                rms_pkg::S_OUT: begin
                    if (!out_stall) begin
                        state_reg <= rms_pkg::S_IDLE;
                    end
                end
                default: begin
                    state_reg <= rms_pkg::S_IDLE;
                end
            endcase
        end
    end

    // The running slot must always be a valid table entry.
    `ASSERT_IMPL(a_run_valid, clk, rst_n, !cur_v_reg || valid_reg[cur_reg])
    // A result that is stalled is held for the next cycle.
    `ASSERT_SEQ(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // Input is only taken while idle.
    `ASSERT_SEQ(a_busy, clk, rst_n, in_valid && !in_stall, state_reg != rms_pkg::S_IDLE)
    // Checks that admitted utilization stays within the full scale; only util_limit bounds it.
    `ASSERT_IMPL(a_util_cap, clk, rst_n, total_reg <= rms_pkg::UTIL_SCALE)
endmodule

[dv/rate_monotonic_task_scheduler_tb.sv]
// Self-checking testbench for the rate monotonic task scheduler: a directed table, a table fill
// and random scheduler traffic, checked against an in-bench scheduler model.
// Depends on rms_pkg and the rate_monotonic_task_scheduler RTL.
`timescale 1ns / 1ps
module rate_monotonic_task_scheduler_tb;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [1:0] REG_UTIL_LIMIT = 2'd0;

    // Expected result of one scheduler transaction.
    typedef struct packed {
        logic [2:0]  status;
        logic        run_v;
        logic [21:0] run_pid;
        logic        pre_v;
        logic [21:0] pre_pid;
        logic [13:0] util;
    } sched_result_t;

    // One row of the directed table; has_exp marks rows whose answer is typed in.
    typedef struct {
        logic [1:0]    kind;
        logic [21:0]   pid;
        logic [15:0]   period;
        logic [15:0]   comp;
        bit            has_exp;
        sched_result_t exp;
    } sched_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [21:0] pid = '0;
    logic [15:0] task_period = '0;
    logic [15:0] comp_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        running_valid;
    logic [21:0] running_pid;
    logic        preempted_valid;
    logic [21:0] preempted_pid;
    logic [13:0] util_total;

    rate_monotonic_task_scheduler dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scheduler model state.
    logic [13:0] m_limit;
    bit          m_used [NSLOT];
    logic [21:0] m_pid [NSLOT];
    logic [15:0] m_period [NSLOT];
    logic [13:0] m_term [NSLOT];
    logic [1:0]  m_phase [NSLOT];
    logic [31:0] m_deadline [NSLOT];
    logic [31:0] m_now;
    bit          m_cur_v;
    int          m_cur;

    sched_result_t pending_results [$];
    int   fail_count = 0;
    int   cycle_count = 0;
    int   accepted_count = 0;
    int   result_count = 0;
    int   preempt_count = 0;
    bit   long_hold = 1'b0;
    int   hold_cycles = 0;
    logic [21:0] live_pids [$];

    function automatic int unsigned util_sum();
        int unsigned s;
        s = 0;
        for (int i = 0; i < NSLOT; i++)
            if (m_used[i])
                s += m_term[i];
        return s;
    endfunction

    function automatic int find_task(logic [21:0] p);
        for (int i = 0; i < NSLOT; i++)
            if (m_used[i] && m_pid[i] == p)
                return i;
        return -1;
    endfunction

    // Pick the ready task with the shortest period; preempt only on a strictly shorter one.
    function automatic void pick_next(ref sched_result_t r);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (m_used[i] && m_phase[i] == rms_pkg::PH_READY &&
                (best < 0 || m_period[i] < m_period[best]))
                best = i;
        if (best < 0)
            return;
        if (m_cur_v) begin
            if (!(m_period[best] < m_period[m_cur]))
                return;
            m_phase[m_cur] = rms_pkg::PH_READY;
            r.pre_v = 1'b1;
            r.pre_pid = m_pid[m_cur];
        end
        m_phase[best] = rms_pkg::PH_RUN;
        m_cur_v = 1'b1;
        m_cur = best;
    endfunction

    function automatic sched_result_t predict_schedule(logic [1:0] k, logic [21:0] p,
                                                       logic [15:0] per, logic [15:0] cmp);
        sched_result_t r;
        longint unsigned term;
        int s;
        r = '0;
        r.status = rms_pkg::ST_OK;
        case (k)
            rms_pkg::KIND_REG:
            begin
                if (per == 16'd0)
                    r.status = rms_pkg::ST_ZERO_PER;
                else begin
                    term = (longint'(cmp) * 10000) / per;
                    if (util_sum() + term > m_limit)
                        r.status = rms_pkg::ST_REFUSED;
                    else begin
                        r.status = rms_pkg::ST_FULL;
                        for (int i = 0; i < NSLOT; i++)
                            if (!m_used[i]) begin
                                m_used[i] = 1'b1;
                                m_pid[i] = p;
                                m_period[i] = per;
                                m_term[i] = term[13:0];
                                m_phase[i] = rms_pkg::PH_NEW;
                                m_deadline[i] = '0;
                                r.status = rms_pkg::ST_OK;
                                break;
                            end
                    end
                end
            end
            rms_pkg::KIND_YIELD:
            begin
                s = find_task(p);
                if (s < 0)
                    r.status = rms_pkg::ST_NOT_FOUND;
                else begin
                    if (m_phase[s] == rms_pkg::PH_SLEEP || m_phase[s] == rms_pkg::PH_NEW) begin
                        m_deadline[s] = m_now + {16'd0, m_period[s]};
                        m_phase[s] = rms_pkg::PH_SLEEP;
                    end else begin
                        m_deadline[s] = m_deadline[s] + {16'd0, m_period[s]};
                        m_phase[s] = (m_deadline[s] > m_now) ? rms_pkg::PH_SLEEP
                                                             : rms_pkg::PH_READY;
                    end
                    if (m_cur_v && m_cur == s)
                        m_cur_v = 1'b0;
                    pick_next(r);
                end
            end
            rms_pkg::KIND_DEREG:
            begin
                s = find_task(p);
                if (s < 0)
                    r.status = rms_pkg::ST_NOT_FOUND;
                else begin
                    m_used[s] = 1'b0;
                    if (m_cur_v && m_cur == s) begin
                        m_cur_v = 1'b0;
                        pick_next(r);
                    end
                end
            end
            default:
            begin
                m_now = m_now + 32'd1;
                for (int i = 0; i < NSLOT; i++)
                    if (m_used[i] && m_phase[i] == rms_pkg::PH_SLEEP && m_deadline[i] <= m_now)
                        m_phase[i] = rms_pkg::PH_READY;
                pick_next(r);
            end
        endcase
        r.run_v = m_cur_v;
        r.run_pid = m_cur_v ? m_pid[m_cur] : 22'd0;
        r.util = 14'(util_sum());
        return r;
    endfunction

    // Result checker: compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, status);
                fail_count++;
            end else begin
                sched_result_t e;
                e = pending_results.pop_front();
                if (preempted_valid)
                    preempt_count <= preempt_count + 1;
                if (e.status !== status || e.run_v !== running_valid ||
                    e.run_pid !== running_pid || e.pre_v !== preempted_valid ||
                    e.pre_pid !== preempted_pid || e.util !== util_total) begin
                    $display("%0t: mismatch expected st=%0d run=%0d/%0h pre=%0d/%0h util=%0d",
                             $time, e.status, e.run_v, e.run_pid, e.pre_v, e.pre_pid, e.util);
                    $display("%0t:          actual   st=%0d run=%0d/%0h pre=%0d/%0h util=%0d",
                             $time, status, running_valid, running_pid, preempted_valid,
                             preempted_pid, util_total);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off counted and released here.
    always @(posedge clk)
    begin
        if (long_hold) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 400)
                long_hold = 1'b0;
        end else if (cycle_count % 1000 < 300)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_util_limit(logic [13:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_UTIL_LIMIT; pwdata <= {18'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        m_limit = v;
    endtask

    // Offer one transaction, hold it until accepted, and queue its prediction.
    task automatic send_item(logic [1:0] k, logic [21:0] p, logic [15:0] per,
                             logic [15:0] cmp, bit has_exp, sched_result_t exp);
        sched_result_t r;
        r = predict_schedule(k, p, per, cmp);
        if (has_exp && r !== exp) begin
            $display("%0t: table row disagrees with model expected=%h model=%h",
                     $time, exp, r);
            fail_count++;
        end
        pending_results.push_back(has_exp ? exp : r);
        in_valid <= 1'b1;
        kind <= k; pid <= p; task_period <= per; comp_ms <= cmp;
        do @(posedge clk); while (in_stall);
        accepted_count++;
    endtask

    task automatic drain_all();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Bursty random gap after an item.
    int burst_left = 0;
    task automatic sender_gap();
        if (burst_left > 0)
            burst_left--;
        else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Random item biased toward well-formed register/yield/tick sequences on a small pid set.
    task automatic random_item();
        logic [1:0]  k;
        logic [21:0] p;
        logic [15:0] per, cmp;
        int sel;
        sel = $urandom_range(0, 99);
        per = 16'($urandom_range(1, 40));
        cmp = 16'($urandom_range(0, 8));
        if (live_pids.size() != 0)
            p = live_pids[$urandom_range(0, live_pids.size() - 1)];
        else
            p = 22'($urandom_range(1, 12));
        if (sel < 15) begin
            k = rms_pkg::KIND_REG;
            p = 22'($urandom_range(1, 12));
            if ($urandom_range(0, 9) == 0) begin
                p = 22'($urandom);
                per = 16'($urandom);
                cmp = 16'($urandom);
            end
            live_pids.push_back(p);
        end else if (sel < 40)
            k = rms_pkg::KIND_YIELD;
        else if (sel < 47) begin
            k = rms_pkg::KIND_DEREG;
            if ($urandom_range(0, 4) == 0)
                p = 22'($urandom);
        end else begin
            k = rms_pkg::KIND_TICK;
            p = 22'($urandom); per = 16'($urandom); cmp = 16'($urandom);
        end
        if (live_pids.size() > 40)
            void'(live_pids.pop_front());
        send_item(k, p, per, cmp, 1'b0, '0);
    endtask

    sched_row_t dir_rows [$];

    function automatic sched_row_t row(logic [1:0] k, logic [21:0] p, logic [15:0] per,
                                       logic [15:0] cmp, bit he, sched_result_t e);
        sched_row_t t;
        t.kind = k; t.pid = p; t.period = per; t.comp = cmp;
        t.has_exp = he; t.exp = e;
        return t;
    endfunction

    // Answer with nothing running and nothing demoted.
    function automatic sched_result_t idle_answer(logic [2:0] st, logic [13:0] u);
        sched_result_t r;
        r = '0;
        r.status = st;
        r.util = u;
        return r;
    endfunction

    initial
    begin
        m_limit = rms_pkg::UTIL_RESET;
        m_now = '0;
        m_cur_v = 1'b0;
        m_cur = 0;
        for (int i = 0; i < NSLOT; i++) begin
            m_used[i] = 1'b0; m_pid[i] = '0; m_period[i] = '0;
            m_term[i] = '0; m_phase[i] = rms_pkg::PH_READY; m_deadline[i] = '0;
        end

        // Directed table: reset answers, field extremes, each kind, and the not-found, zero-period and refused codes.
        dir_rows.push_back(row(rms_pkg::KIND_TICK, 22'h3FFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                               idle_answer(rms_pkg::ST_OK, 14'd0)));
        dir_rows.push_back(row(rms_pkg::KIND_YIELD, 22'h3FFFFF, 16'd0, 16'd0, 1'b1,
                               idle_answer(rms_pkg::ST_NOT_FOUND, 14'd0)));
        dir_rows.push_back(row(rms_pkg::KIND_DEREG, 22'd0, 16'd0, 16'd0, 1'b1,
                               idle_answer(rms_pkg::ST_NOT_FOUND, 14'd0)));
        dir_rows.push_back(row(rms_pkg::KIND_REG, 22'd5, 16'd0, 16'hFFFF, 1'b1,
                               idle_answer(rms_pkg::ST_ZERO_PER, 14'd0)));
        dir_rows.push_back(row(rms_pkg::KIND_REG, 22'd5, 16'd1, 16'hFFFF, 1'b1,
                               idle_answer(rms_pkg::ST_REFUSED, 14'd0)));
        dir_rows.push_back(row(rms_pkg::KIND_REG, 22'h3FFFFF, 16'hFFFF, 16'd0, 1'b1,
                               idle_answer(rms_pkg::ST_OK, 14'd0)));
        dir_rows.push_back(row(rms_pkg::KIND_REG, 22'd0, 16'd10, 16'd1, 1'b1,
                               idle_answer(rms_pkg::ST_OK, 14'd1000)));
        dir_rows.push_back(row(rms_pkg::KIND_REG, 22'd7, 16'd5, 16'd1, 1'b0, '0));
        dir_rows.push_back(row(rms_pkg::KIND_REG, 22'd7, 16'd20, 16'd1, 1'b0, '0));
        dir_rows.push_back(row(rms_pkg::KIND_YIELD, 22'd0, 16'd0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(rms_pkg::KIND_YIELD, 22'd7, 16'd0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(rms_pkg::KIND_YIELD, 22'h3FFFFF, 16'd0, 16'd0, 1'b0, '0));
        for (int i = 0; i < 10; i++)
            dir_rows.push_back(row(rms_pkg::KIND_TICK, 22'd0, 16'd0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(rms_pkg::KIND_YIELD, 22'd7, 16'd0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(rms_pkg::KIND_DEREG, 22'd0, 16'd0, 16'd0, 1'b0, '0));
        dir_rows.push_back(row(rms_pkg::KIND_DEREG, 22'd7, 16'd0, 16'd0, 1'b0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].kind, dir_rows[i].pid, dir_rows[i].period,
                      dir_rows[i].comp, dir_rows[i].has_exp, dir_rows[i].exp);
            sender_gap();
        end
        in_valid <= 1'b0;
        drain_all();

        // Fill the table at the full-scale limit to reach the full-table answer.
        write_util_limit(14'd10000);
        for (int i = 0; i < NSLOT + 2; i++)
        begin
            send_item(rms_pkg::KIND_REG, 22'(100 + i), 16'd1000, 16'd1, 1'b0, '0);
            live_pids.push_back(22'(100 + i));
        end
        in_valid <= 1'b0;
        drain_all();

        // Random phases across several admission limits, extremes included.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_util_limit(14'd0);
                1: write_util_limit(14'd10000);
                2: write_util_limit(rms_pkg::UTIL_RESET);
                3: write_util_limit(14'($urandom_range(1, 9999)));
                default: write_util_limit(14'd10000);
            endcase
            for (int n = 0; n < 260; n++)
            begin
                // The receiver holds off on its own while the sender keeps offering.
                if (ph == 2 && n == 50)
                    long_hold = 1'b1;
                if (ph == 3 && n == 100) begin
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                random_item();
                if (!(ph == 2 && n >= 50 && n < 60))
                    sender_gap();
            end
            in_valid <= 1'b0;
            drain_all();
        end

        $display("Covered %0d transactions, %0d results, %0d preemptions, five limits.",
                 accepted_count, result_count, preempt_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/rms_pkg.sv
design/rate_monotonic_task_scheduler.sv
dv/rate_monotonic_task_scheduler_tb.sv
